### rtl/clb_pkg.sv
`timescale 1ns / 1ps

package clb_pkg;

   localparam int NUM_W   = 10;
   localparam int TALLY_W = 13;
   localparam int OUT_MAX = 32;

   localparam logic [1:0] CSR_ACTIVE_CLUSTERS = 2'd0;
   localparam logic [1:0] CSR_LIST_CAPACITY   = 2'd1;
   localparam logic [1:0] CSR_LIGHT_CAP       = 2'd2;

   typedef enum logic [1:0] {
      ACT_LOAD  = 2'd0,
      ACT_CLEAR = 2'd1,
      ACT_BIN   = 2'd2,
      ACT_READ  = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_BIN_RUN,
      ST_BIN_DRAIN,
      ST_EMIT,
      ST_RD_CNT,
      ST_RD_CHK,
      ST_RD_ADDR,
      ST_RD_DATA
   } back_state_type;

   typedef struct packed {
      logic [1:0]         action;
      logic [11:0]        cluster_index;
      logic signed [31:0] box_min_x;
      logic signed [31:0] box_min_y;
      logic signed [31:0] box_min_z;
      logic signed [31:0] box_max_x;
      logic signed [31:0] box_max_y;
      logic signed [31:0] box_max_z;
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic signed [31:0] center_z;
      logic [30:0]        light_radius;
   } req_type;

   typedef struct packed {
      logic [NUM_W-1:0]   light_number;
      logic [TALLY_W-1:0] tally;
      logic               entry_valid;
      logic               dropped;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [12:0] active_clusters;
      logic [5:0]  list_capacity;
      logic [10:0] light_cap;
   } cfg_type;

   typedef struct packed {
      logic [31:0] min_x;
      logic [31:0] min_y;
      logic [31:0] min_z;
      logic [31:0] max_x;
      logic [31:0] max_y;
      logic [31:0] max_z;
   } box_type;

   typedef struct packed {
      action_type  kind;
      logic        load_ok;
      logic [11:0] cluster_index;
      box_type     box;
      logic [31:0] center_x;
      logic [31:0] center_y;
      logic [31:0] center_z;
      logic [61:0] rsq;
   } job_type;

endpackage

### rtl/clb_ram.sv
`timescale 1ns / 1ps

module clb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                      wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                      rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/clb_front.sv
`timescale 1ns / 1ps

module clb_front
   import clb_pkg::*;
#(
   parameter int CLUSTERS = 4096
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   input  logic    hold,
   output logic    job_valid,
   input  logic    job_ready,
   output job_type job
);

   localparam int QDEPTH = 2;

   job_type     q_ff [QDEPTH];
   logic        wp_ff, wp_in;
   logic        rp_ff, rp_in;
   logic [1:0]  cnt_ff, cnt_in;
   job_type     job_new;
   logic        push;
   logic        pop;

   always_comb begin
      job_new.kind          = action_type'(req_payload.action);
      job_new.load_ok       = 32'(req_payload.cluster_index) < 32'(CLUSTERS);
      job_new.cluster_index = req_payload.cluster_index;
      job_new.box.min_x     = req_payload.box_min_x;
      job_new.box.min_y     = req_payload.box_min_y;
      job_new.box.min_z     = req_payload.box_min_z;
      job_new.box.max_x     = req_payload.box_max_x;
      job_new.box.max_y     = req_payload.box_max_y;
      job_new.box.max_z     = req_payload.box_max_z;
      job_new.center_x      = req_payload.center_x;
      job_new.center_y      = req_payload.center_y;
      job_new.center_z      = req_payload.center_z;
      job_new.rsq           = 62'(req_payload.light_radius) * 62'(req_payload.light_radius);
   end

   assign req_ready = (cnt_ff != 2'(QDEPTH)) && !hold;
   assign push      = req_valid && req_ready;
   assign job_valid = cnt_ff != 2'd0;
   assign pop       = job_valid && job_ready;
   assign job       = q_ff[rp_ff];

   always_comb begin
      wp_in  = push ? !wp_ff : wp_ff;
      rp_in  = pop ? !rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         q_ff[wp_ff] <= job_new;
      end
   end

endmodule

### rtl/clb_back.sv
`timescale 1ns / 1ps

module clb_back
   import clb_pkg::*;
#(
   parameter int CLUSTERS = 4096,
   parameter int SLOTS    = 32,
   parameter int LIGHTS   = 1024
) (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    job_valid,
   output logic    job_ready,
   input  job_type job,
   output logic    hold,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   localparam int CIW = CLUSTERS > 1 ? $clog2(CLUSTERS) : 1;
   localparam int NCW = $clog2(CLUSTERS + 1);
   localparam int SCW = $clog2(SLOTS + 1);
   localparam int LCW = $clog2(LIGHTS + 1);
   localparam int EAW = CLUSTERS * SLOTS > 1 ? $clog2(CLUSTERS * SLOTS) : 1;

   function automatic logic [31:0] axis_dist(logic [31:0] v, logic [31:0] lo,
                                             logic [31:0] hi);
      logic [31:0] d;
      if ($signed(v) < $signed(lo)) begin
         d = lo - v;
      end else if ($signed(hi) < $signed(v)) begin
         d = v - hi;
      end else begin
         d = 32'd0;
      end
      return d;
   endfunction

   function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? {64{1'b1}} : s[63:0];
   endfunction

   back_state_type state_ff, state_in;
   job_type        job_ff, job_in;
   rsp_type        res_ff, res_in;
   rsp_type        rsp_ff, rsp_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           init_ff, init_in;
   logic [NCW-1:0] iss_ff, iss_in;
   logic [LCW-1:0] lights_ff, lights_in;
   logic [LCW-1:0] num_ff, num_in;
   logic [NCW-1:0] joined_ff, joined_in;
   logic [SCW-1:0] n_ff, n_in;
   logic [SCW-1:0] k_ff, k_in;
   logic [3:0]     pv_ff, pv_in;

   logic [CIW-1:0] a_idx_ff;
   logic [31:0]    b_d_ff [3];
   logic [SCW-1:0] b_n_ff;
   logic           b_ok_ff;
   logic [CIW-1:0] b_idx_ff;
   logic [63:0]    c_sq_ff [3];
   logic [SCW-1:0] c_n_ff;
   logic           c_ok_ff;
   logic [CIW-1:0] c_idx_ff;
   logic [63:0]    d_s01_ff;
   logic [63:0]    d_sqz_ff;
   logic [SCW-1:0] d_n_ff;
   logic           d_ok_ff;
   logic [CIW-1:0] d_idx_ff;

   logic [NCW-1:0] nclus;
   logic [SCW-1:0] cap;
   logic [LCW-1:0] lcap;
   logic           out_free;
   logic           issue;
   logic           emit;
   rsp_type        emit_data;
   logic           hit;
   logic [63:0]    dist_sum;
   logic           rd_last;

   logic           box_we;
   box_type        box_rdata;
   logic           cnt_we;
   logic [CIW-1:0] cnt_waddr;
   logic [SCW-1:0] cnt_wdata;
   logic [CIW-1:0] cnt_raddr;
   logic [SCW-1:0] cnt_rdata;
   logic [EAW-1:0] ent_waddr;
   logic [EAW-1:0] ent_raddr;
   logic [NUM_W-1:0] ent_rdata;

   assign nclus = (32'(cfg.active_clusters) < 32'(CLUSTERS)) ?
                  NCW'(cfg.active_clusters) : NCW'(CLUSTERS);
   assign cap   = (32'(cfg.list_capacity) < 32'(SLOTS)) ?
                  SCW'(cfg.list_capacity) : SCW'(SLOTS);
   assign lcap  = (32'(cfg.light_cap) < 32'(LIGHTS)) ?
                  LCW'(cfg.light_cap) : LCW'(LIGHTS);

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign hold     = init_ff;
   assign dist_sum = sat_add(d_s01_ff, d_sqz_ff);
   assign hit      = pv_ff[3] && d_ok_ff && (dist_sum <= job_ff.rsq);
   assign rd_last  = (32'(k_ff) + 32'd1 == 32'(n_ff)) || (32'(k_ff) + 32'd1 == 32'(OUT_MAX));

   assign cnt_raddr = (state_ff == ST_BIN_RUN) ? iss_ff[CIW-1:0] :
                      CIW'(job_ff.cluster_index);
   assign ent_raddr = EAW'(CIW'(job_ff.cluster_index)) * EAW'(SLOTS) + EAW'(k_ff);
   assign ent_waddr = EAW'(d_idx_ff) * EAW'(SLOTS) + EAW'(d_n_ff);

   always_comb begin
      state_in  = state_ff;
      job_in    = job_ff;
      res_in    = res_ff;
      init_in   = init_ff;
      iss_in    = iss_ff;
      lights_in = lights_ff;
      num_in    = num_ff;
      joined_in = hit ? joined_ff + NCW'(1) : joined_ff;
      n_in      = n_ff;
      k_in      = k_ff;
      job_ready = 1'b0;
      issue     = 1'b0;
      emit      = 1'b0;
      emit_data = res_ff;
      box_we    = 1'b0;
      cnt_we    = hit;
      cnt_waddr = d_idx_ff;
      cnt_wdata = d_n_ff + SCW'(1);

      unique case (state_ff)
         ST_IDLE: begin
            job_ready = 1'b1;
            if (job_valid) begin
               job_in = job;
               unique case (job.kind)
                  ACT_LOAD: begin
                     box_we = job.load_ok;
                  end
                  ACT_CLEAR: begin
                     lights_in = '0;
                     iss_in    = '0;
                     state_in  = ST_SWEEP;
                  end
                  ACT_BIN: begin
                     if (lights_ff >= lcap) begin
                        res_in         = '0;
                        res_in.dropped = 1'b1;
                        res_in.last    = 1'b1;
                        state_in       = ST_EMIT;
                     end else begin
                        num_in    = lights_ff;
                        lights_in = lights_ff + LCW'(1);
                        joined_in = '0;
                        iss_in    = '0;
                        state_in  = ST_BIN_RUN;
                     end
                  end
                  ACT_READ: begin
                     if (32'(job.cluster_index) >= 32'(nclus)) begin
                        res_in      = '0;
                        res_in.last = 1'b1;
                        state_in    = ST_EMIT;
                     end else begin
                        state_in = ST_RD_CNT;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SWEEP: begin
            cnt_we    = 1'b1;
            cnt_waddr = iss_ff[CIW-1:0];
            cnt_wdata = '0;
            if (32'(iss_ff) == 32'(CLUSTERS - 1)) begin
               iss_in   = '0;
               init_in  = 1'b0;
               state_in = ST_IDLE;
            end else begin
               iss_in = iss_ff + NCW'(1);
            end
         end
         ST_BIN_RUN: begin
            if (iss_ff == nclus) begin
               state_in = ST_BIN_DRAIN;
            end else begin
               issue  = 1'b1;
               iss_in = iss_ff + NCW'(1);
            end
         end
         ST_BIN_DRAIN: begin
            if (pv_ff == '0) begin
               res_in.light_number = NUM_W'(num_ff);
               res_in.tally        = TALLY_W'(joined_ff);
               res_in.entry_valid  = 1'b1;
               res_in.dropped      = 1'b0;
               res_in.last         = 1'b1;
               state_in            = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_RD_CNT: begin
            state_in = ST_RD_CHK;
         end
         ST_RD_CHK: begin
            if (cnt_rdata == '0) begin
               res_in      = '0;
               res_in.last = 1'b1;
               state_in    = ST_EMIT;
            end else begin
               n_in     = cnt_rdata;
               k_in     = '0;
               state_in = ST_RD_ADDR;
            end
         end
         ST_RD_ADDR: begin
            state_in = ST_RD_DATA;
         end
         ST_RD_DATA: begin
            if (out_free) begin
               emit                   = 1'b1;
               emit_data.light_number = ent_rdata;
               emit_data.tally        = TALLY_W'(n_ff);
               emit_data.entry_valid  = 1'b1;
               emit_data.dropped      = 1'b0;
               emit_data.last         = rd_last;
               if (rd_last) begin
                  state_in = ST_IDLE;
               end else begin
                  k_in     = k_ff + SCW'(1);
                  state_in = ST_RD_ADDR;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      pv_in        = {pv_ff[2:0], issue};
      rsp_valid_in = emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      rsp_in       = emit ? emit_data : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         init_ff      <= 1'b1;
         iss_ff       <= '0;
         lights_ff    <= '0;
         pv_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         iss_ff       <= iss_in;
         lights_ff    <= lights_in;
         pv_ff        <= pv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      job_ff    <= job_in;
      res_ff    <= res_in;
      rsp_ff    <= rsp_in;
      num_ff    <= num_in;
      joined_ff <= joined_in;
      n_ff      <= n_in;
      k_ff      <= k_in;

      a_idx_ff  <= iss_ff[CIW-1:0];
      b_d_ff[0] <= axis_dist(job_ff.center_x, box_rdata.min_x, box_rdata.max_x);
      b_d_ff[1] <= axis_dist(job_ff.center_y, box_rdata.min_y, box_rdata.max_y);
      b_d_ff[2] <= axis_dist(job_ff.center_z, box_rdata.min_z, box_rdata.max_z);
      b_n_ff    <= cnt_rdata;
      b_ok_ff   <= cnt_rdata < cap;
      b_idx_ff  <= a_idx_ff;
      for (int i = 0; i < 3; i++) begin
         c_sq_ff[i] <= 64'(b_d_ff[i]) * 64'(b_d_ff[i]);
      end
      c_n_ff    <= b_n_ff;
      c_ok_ff   <= b_ok_ff;
      c_idx_ff  <= b_idx_ff;
      d_s01_ff  <= sat_add(c_sq_ff[0], c_sq_ff[1]);
      d_sqz_ff  <= c_sq_ff[2];
      d_n_ff    <= c_n_ff;
      d_ok_ff   <= c_ok_ff;
      d_idx_ff  <= c_idx_ff;
   end

   clb_ram #(
      .WIDTH($bits(box_type)),
      .DEPTH(CLUSTERS)
   ) u_box_ram (
      .clock(clock),
      .we   (box_we),
      .waddr(CIW'(job.cluster_index)),
      .wdata(job.box),
      .raddr(iss_ff[CIW-1:0]),
      .rdata(box_rdata)
   );

   clb_ram #(
      .WIDTH(SCW),
      .DEPTH(CLUSTERS)
   ) u_cnt_ram (
      .clock(clock),
      .we   (cnt_we),
      .waddr(cnt_waddr),
      .wdata(cnt_wdata),
      .raddr(cnt_raddr),
      .rdata(cnt_rdata)
   );

   clb_ram #(
      .WIDTH(NUM_W),
      .DEPTH(CLUSTERS * SLOTS)
   ) u_ent_ram (
      .clock(clock),
      .we   (hit),
      .waddr(ent_waddr),
      .wdata(NUM_W'(num_ff)),
      .raddr(ent_raddr),
      .rdata(ent_rdata)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef NO_ASSERTIONS
   a_pipe_empty_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (pv_ff == '0))
      else $error("bin pipeline busy while idle");

   a_lights_bound: assert property (@(posedge clock) disable iff (reset)
      32'(lights_ff) <= 32'(LIGHTS))
      else $error("light counter above its limit");

   a_hit_room: assert property (@(posedge clock) disable iff (reset)
      hit |-> (d_n_ff < cap))
      else $error("append to a full list");

   a_read_in_list: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RD_DATA && out_free) |-> (k_ff < n_ff))
      else $error("list read past its count");

   a_sweep_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> (!hit && !emit))
      else $error("activity during count sweep");
`endif

endmodule

### rtl/cluster_light_binning.sv
`timescale 1ns / 1ps

// Clustered light binning. Items arrive as beats on the req channel; each one loads a
// cluster box, clears all lists and the light counter, bins a sphere light, or reads
// back one cluster's list. Results leave as beats on the rsp channel, with last set on
// the final beat of an item. Loads and clears give no beat. The csr channel writes
// the active cluster count, the list capacity and the light cap; csr_ready is always high.
// A clear sweeps the list counts, one cluster per cycle. A light streams the active
// clusters through the pipelined box test, one cluster per cycle, and gives its beat
// once the pipeline has drained; past the light cap it gives a dropped beat instead.
// A read fetches the list count, then gives each stored entry after an address step and
// a data step, set by the registered read of the entry memory. A two-entry queue sits
// in front of the engine, so req stays ready while earlier items are still in work.
// After reset the block sweeps the list counts like a clear, with req_ready low; csr
// writes are taken during that time. All results pass through one output register:
// when the receiver holds rsp_ready low, the engine waits and the queue fills.
module cluster_light_binning
   import clb_pkg::*;
#(
   parameter int CLUSTERS = 4096,
   parameter int SLOTS    = 32,
   parameter int LIGHTS   = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_payload,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_data
);

   cfg_type cfg_ff, cfg_in;
   logic    job_valid;
   logic    job_ready;
   job_type job;
   logic    hold;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_ACTIVE_CLUSTERS: cfg_in.active_clusters = csr_data;
            CSR_LIST_CAPACITY:   cfg_in.list_capacity   = csr_data[5:0];
            CSR_LIGHT_CAP:       cfg_in.light_cap       = csr_data[10:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.active_clusters <= 13'd4096;
         cfg_ff.list_capacity   <= 6'd32;
         cfg_ff.light_cap       <= 11'd1024;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   clb_front #(
      .CLUSTERS(CLUSTERS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .hold       (hold),
      .job_valid  (job_valid),
      .job_ready  (job_ready),
      .job        (job)
   );

   clb_back #(
      .CLUSTERS(CLUSTERS),
      .SLOTS   (SLOTS),
      .LIGHTS  (LIGHTS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .job_valid  (job_valid),
      .job_ready  (job_ready),
      .job        (job),
      .hold       (hold),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

endmodule
